FILE: sv/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and character codes for the s-expression delimiter spacer.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int MAX_BYTES = 4;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int IDX_W     = $clog2(MAX_BYTES);

  typedef logic [7:0] byte_t;

  localparam byte_t CH_LPAREN = 8'h28;
  localparam byte_t CH_RPAREN = 8'h29;
  localparam byte_t CH_QUOTE  = 8'h27;
  localparam byte_t CH_BQUOTE = 8'h60;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_AT     = 8'h40;
  localparam byte_t CH_HASH   = 8'h23;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_NL     = 8'h0A;
  localparam byte_t CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_COMMA = 2'd1,
    PEND_HASH  = 2'd2
  } pend_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      has_byte;
    logic                      fin;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t head;
  } q_status_t;

endpackage

FILE: sv/sexpr_delimiter_spacer.sv
// ----------------------------------------------------------------------------
// sexpr_delimiter_spacer
// Rewrites Lisp source text so that delimiters stand apart at whitespace.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_byte, in_is_final
//   out_     output     out_valid/out_stall out_byte, out_has_byte,
//                                           out_run_last, out_text_end
//
// An item that yields n results (n from 0 to 4) is walked by the back end
// one result per cycle while out_stall does not hold a valid output.
// An item with no result (comment byte, held prefix) pushes no queue entry.
// Two-entry queue between front and back; in_stall rises when it is full.
// Synchronous active-low reset clears text state, queue and output valid.
// ----------------------------------------------------------------------------
module sexpr_delimiter_spacer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sds_pkg::byte_t in_byte,
  input  logic           in_is_final,
  output logic           out_valid,
  input  logic           out_stall,
  output sds_pkg::byte_t out_byte,
  output logic           out_has_byte,
  output logic           out_run_last,
  output logic           out_text_end
);
  import sds_pkg::*;

  logic      q_full, push, pop;
  entry_t    push_entry;
  q_status_t status;

  sds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_is_final(in_is_final),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  sds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (q_full),
    .status    (status)
  );

  sds_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .status      (status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_has_byte(out_has_byte),
    .out_run_last(out_run_last),
    .out_text_end(out_text_end)
  );

`ifndef ASSERT_OFF
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_run_last && out_text_end && out_byte == 8'h00)
    else $error("byteless result not at end of text");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_end |-> out_run_last)
    else $error("text end without run end");

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> status.valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("push into full queue");
`endif

endmodule

FILE: sv/sds_front.sv
// ----------------------------------------------------------------------------
// sds_front
// Accepts source bytes, tracks string/comment/prefix state and builds one
// queue entry holding every byte that the item produces.
// ----------------------------------------------------------------------------
module sds_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sds_pkg::byte_t  in_byte,
  input  logic            in_is_final,
  input  logic            q_full,
  output logic            push,
  output sds_pkg::entry_t push_entry
);
  import sds_pkg::*;

  logic  str_r, str_nxt;
  logic  cmt_r, cmt_nxt;
  pend_t pend_r, pend_nxt;
  logic  accept;
  logic  done;
  entry_t ent;

  function automatic entry_t add(entry_t e, byte_t b);
    e.bytes[e.count[IDX_W-1:0]] = b;
    e.count = e.count + CNT_W'(1);
    return e;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    ent          = '0;
    ent.has_byte = 1'b1;
    ent.fin      = in_is_final;
    str_nxt      = str_r;
    cmt_nxt      = cmt_r;
    pend_nxt     = pend_r;
    done         = 1'b0;
    if (str_r) begin
      ent = add(ent, in_byte);
      if (in_byte == CH_DQUOTE) str_nxt = 1'b0;
    end else if (cmt_r) begin
      if (in_byte == CH_NL) begin
        cmt_nxt = 1'b0;
        ent = add(ent, CH_SPACE);
        ent = add(ent, CH_NL);
      end
    end else begin
      pend_nxt = PEND_NONE;
      case (pend_r)
        PEND_COMMA: begin
          if (in_byte == CH_AT) begin
            ent  = add(ent, CH_AT);
            ent  = add(ent, CH_SPACE);
            done = 1'b1;
          end else begin
            ent = add(ent, CH_SPACE);
          end
        end
        PEND_HASH: begin
          if (in_byte == CH_LPAREN) begin
            ent  = add(ent, CH_SPACE);
            ent  = add(ent, CH_HASH);
            ent  = add(ent, CH_LPAREN);
            ent  = add(ent, CH_SPACE);
            done = 1'b1;
          end else begin
            ent = add(ent, CH_HASH);
          end
        end
        default: ;
      endcase
      if (!done) begin
        case (in_byte)
          CH_DQUOTE: begin
            str_nxt = 1'b1;
            ent = add(ent, in_byte);
          end
          CH_LPAREN, CH_RPAREN, CH_QUOTE, CH_BQUOTE: begin
            ent = add(ent, CH_SPACE);
            ent = add(ent, in_byte);
            ent = add(ent, CH_SPACE);
          end
          CH_COMMA: begin
            ent = add(ent, CH_SPACE);
            ent = add(ent, CH_COMMA);
            pend_nxt = PEND_COMMA;
          end
          CH_HASH: pend_nxt = PEND_HASH;
          CH_SEMI: cmt_nxt = 1'b1;
          CH_NL: begin
            ent = add(ent, CH_SPACE);
            ent = add(ent, CH_NL);
          end
          default: ent = add(ent, in_byte);
        endcase
      end
    end
    if (in_is_final) begin
      if (pend_nxt == PEND_COMMA) ent = add(ent, CH_SPACE);
      else if (pend_nxt == PEND_HASH) ent = add(ent, CH_HASH);
      str_nxt  = 1'b0;
      cmt_nxt  = 1'b0;
      pend_nxt = PEND_NONE;
      if (ent.count == '0) begin
        ent.count    = CNT_W'(1);
        ent.has_byte = 1'b0;
      end
    end
  end

  assign push       = accept && (ent.count != '0);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str_r  <= 1'b0;
      cmt_r  <= 1'b0;
      pend_r <= PEND_NONE;
    end else if (accept) begin
      str_r  <= str_nxt;
      cmt_r  <= cmt_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

FILE: sv/sds_queue.sv
// ----------------------------------------------------------------------------
// sds_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module sds_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sds_pkg::entry_t    push_entry,
  input  logic               pop,
  output logic               full,
  output sds_pkg::q_status_t status
);
  import sds_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full         = (cnt_r == 2'd2);
  assign status.valid = (cnt_r != 2'd0);
  assign status.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: sv/sds_back.sv
// ----------------------------------------------------------------------------
// sds_back
// Walks the queue head into the output register, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module sds_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sds_pkg::q_status_t status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sds_pkg::byte_t     out_byte,
  output logic               out_has_byte,
  output logic               out_run_last,
  output logic               out_text_end
);
  import sds_pkg::*;

  logic             valid_r;
  byte_t            byte_r;
  logic             has_r, last_r, end_r;
  logic [IDX_W-1:0] idx_r;
  logic             load;
  logic             is_last;

  assign load    = status.valid && (!valid_r || !out_stall);
  assign is_last = ((CNT_W'(idx_r) + CNT_W'(1)) == status.head.count);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? '0 : idx_r + IDX_W'(1);
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= status.head.bytes[idx_r];
      has_r  <= status.head.has_byte;
      last_r <= is_last;
      end_r  <= is_last && status.head.fin;
    end
  end

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign out_has_byte = has_r;
  assign out_run_last = last_r;
  assign out_text_end = end_r;

endmodule
